// File: design/fft_spectrum_peak_finder_macros.svh
// Assertion macros for the spectrum peak finder.
// Taken in by `include in the files that check their own logic.
`ifndef FFT_SPECTRUM_PEAK_FINDER_MACROS_SVH
`define FFT_SPECTRUM_PEAK_FINDER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define FSP_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);
// antecedent holds -> consequent holds in the next cycle
`define FSP_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSP_ASSERT_IMP(label, clock, reset, ante, cons, msg)
`define FSP_ASSERT_NEXT(label, clock, reset, ante, cons, msg)
`endif
`endif

// File: design/fsp_pkg.sv
// Shared types, constants and elaboration-time twiddle generation for the
// spectrum peak finder. No dependencies.
package fsp_pkg;

  localparam int POINTS_DEFAULT       = 128;
  localparam int TWIDDLE_BITS_DEFAULT = 16;
  localparam int SAMPLE_BITS_DEFAULT  = 16;

  localparam int DATA_W   = 24;            // real or imaginary part
  localparam int TW_W     = 24;            // twiddle storage, signed
  localparam int PROD_W   = DATA_W + TW_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int SQ_W     = 50;            // 4*(re^2+im^2)
  localparam int ROOT_W   = SQ_W / 2;
  localparam int STAGE_W  = 3;
  localparam int BIN_W    = 6;
  localparam int AMP_W    = 16;
  localparam int FREQ_W   = 19;
  localparam int RATE_W   = 20;
  localparam int TW_COUNT = 64;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);
  localparam logic [1:0]        REG_RATE   = 2'd0;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic signed [TW_W-1:0] tw_tab_t [TW_COUNT];

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = (ACC_W+1)'(signed'(24'sh7FFFFF));
    lo = (ACC_W+1)'(signed'(24'sh800000));
    if (v > hi) return 24'sh7FFFFF;
    else if (v < lo) return 24'sh800000;
    else return v[DATA_W-1:0];
  endfunction

  // sin(pi*i/64) in Q1.f, Taylor series in Q30 (elaboration only)
  function automatic logic signed [63:0] sine_q(input int i, input int f);
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x = (PI_Q30 * 64'(i)) >> 6;
    term = x;
    sum = signed'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        7: term = term / 210;
        8: term = term / 272;
        9: term = term / 342;
        default: term = term / 420;
      endcase
      if (n % 2 == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + (64'sd1 <<< (29 - f))) >>> (30 - f);
    if (v > ((64'sd1 <<< f) - 1)) v = (64'sd1 <<< f) - 1;
    return v;
  endfunction

  function automatic tw_tab_t make_tw_re(input int f);
    tw_tab_t t;
    for (int m = 0; m < TW_COUNT; m++) begin
      if (m <= 32) t[m] = TW_W'(sine_q(32 - m, f));
      else t[m] = TW_W'(-sine_q(m - 32, f));
    end
    return t;
  endfunction

  function automatic tw_tab_t make_tw_im(input int f);
    tw_tab_t t;
    for (int m = 0; m < TW_COUNT; m++) begin
      if (m <= 32) t[m] = TW_W'(-sine_q(m, f));
      else t[m] = TW_W'(-sine_q(64 - m, f));
    end
    return t;
  endfunction

endpackage

// File: design/fft_spectrum_peak_finder.sv
// Spectrum peak finder top level: sample capture, FFT sequencer, bin scan.
// Depends on fsp_pkg, fsp_ram, fsp_isqrt and the assertion macro header.
//
// Samples are taken one per cycle (start high, busy low) and written in
// bit-reversed order into a single-port-pair frame RAM. The POINTS-th sample
// raises busy; the block then runs log2(POINTS)*POINTS/2 butterflies on one
// shared 24x24 multiplier, each reading both points, forming the four real
// products and writing both points back, then scans bins 0..POINTS/2-1,
// each bin waiting on the bit-serial square root. Each result appears for
// exactly one cycle with valid high and cannot be held off; last marks the
// final bin, which carries the frame's peak. sample_rate_hz sits at byte
// address 0.
`include "fft_spectrum_peak_finder_macros.svh"

module fft_spectrum_peak_finder #(
  parameter int POINTS       = fsp_pkg::POINTS_DEFAULT,
  parameter int TWIDDLE_BITS = fsp_pkg::TWIDDLE_BITS_DEFAULT,
  parameter int SAMPLE_BITS  = fsp_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic                              busy,
  output logic                              valid,
  output logic [fsp_pkg::BIN_W-1:0]         bin_index,
  output logic [fsp_pkg::AMP_W-1:0]         amplitude,
  output logic [fsp_pkg::FREQ_W-1:0]        frequency_hz,
  output logic                              last,
  output logic [fsp_pkg::BIN_W-1:0]         peak_bin,
  output logic [fsp_pkg::AMP_W-1:0]         peak_amplitude,
  output logic [fsp_pkg::FREQ_W-1:0]        peak_frequency_hz,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [1:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int AW  = $clog2(POINTS);
  localparam int DW  = fsp_pkg::DATA_W;
  localparam int F   = TWIDDLE_BITS - 1;
  localparam int ACW = fsp_pkg::ACC_W;
  localparam logic [AW-1:0] IDX_LAST  = AW'(POINTS - 1);
  localparam logic [AW-1:0] HALF_LAST = AW'(POINTS / 2 - 1);
  localparam logic [fsp_pkg::STAGE_W-1:0] STAGE_LAST = fsp_pkg::STAGE_W'(AW - 1);
  localparam logic signed [ACW-1:0] HALF_LSB = ACW'(1) <<< (F - 1);
  localparam fsp_pkg::tw_tab_t TW_RE = fsp_pkg::make_tw_re(F);
  localparam fsp_pkg::tw_tab_t TW_IM = fsp_pkg::make_tw_im(F);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_RD_B  = 5'd1;
  localparam logic [4:0] ST_RD_A  = 5'd2;
  localparam logic [4:0] ST_M0    = 5'd3;
  localparam logic [4:0] ST_M1    = 5'd4;
  localparam logic [4:0] ST_M2    = 5'd5;
  localparam logic [4:0] ST_M3    = 5'd6;
  localparam logic [4:0] ST_M4    = 5'd7;
  localparam logic [4:0] ST_WR_A  = 5'd8;
  localparam logic [4:0] ST_WR_B  = 5'd9;
  localparam logic [4:0] ST_K_RD  = 5'd10;
  localparam logic [4:0] ST_K_LAT = 5'd11;
  localparam logic [4:0] ST_S0    = 5'd12;
  localparam logic [4:0] ST_S1    = 5'd13;
  localparam logic [4:0] ST_S2    = 5'd14;
  localparam logic [4:0] ST_S3    = 5'd15;
  localparam logic [4:0] ST_SQRT  = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;

  logic [fsp_pkg::RATE_W-1:0]  rate;
  logic [AW-1:0]               fill;
  logic [AW-1:0]               bf;
  logic [AW-1:0]               k;
  logic [fsp_pkg::STAGE_W-1:0] stage;
  logic [fsp_pkg::BIN_W-1:0]   best_bin;
  logic [fsp_pkg::AMP_W-1:0]   best_amp;

  logic signed [DW-1:0] odd_re, odd_im, even_re, even_im;
  logic signed [fsp_pkg::PROD_W-1:0] prod;
  logic signed [ACW-1:0] acc_r, acc_i;

  // RAM ports
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [2*DW-1:0]     wdata, rdata;

  // butterfly addressing
  logic [AW:0]         grp_base;
  logic [AW-1:0]       j_off, a_addr, b_addr, rev_fill;
  logic [12:0]         tw_wide;
  logic [5:0]          tw_idx;
  logic signed [DW-1:0] wr, wi;

  logic signed [DW-1:0] mult_a, mult_b;
  logic signed [ACW-1:0] tr, ti;
  logic signed [ACW:0]   sum_r, sum_i, dif_r, dif_i;
  logic signed [DW-1:0]  s_ext;

  logic                        sq_go, sq_done;
  logic [fsp_pkg::ROOT_W-1:0]  sq_root;
  logic [fsp_pkg::AMP_W-1:0]   amp;
  logic                        take_peak;
  logic [fsp_pkg::BIN_W-1:0]   k6, new_bin;
  logic [fsp_pkg::AMP_W-1:0]   new_amp;
  logic [25:0]                 f_prod, pf_prod;
  logic                        in_take, cfg_wr;

  assign busy    = (state != ST_IDLE);
  assign in_take = start && !busy;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (paddr == fsp_pkg::REG_RATE) ? 32'(rate) : 32'd0;
  assign s_ext   = DW'(sample);

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      rev_fill[i] = fill[AW-1-i];
    end
  end

  assign grp_base = (({1'b0, bf} >> stage) << (stage + 1'b1));
  assign j_off    = bf & ~({AW{1'b1}} << stage);
  assign a_addr   = grp_base[AW-1:0] | j_off;
  assign b_addr   = a_addr | (AW'(1) << stage);
  assign tw_wide  = 13'(j_off) << 6;
  assign tw_idx   = 6'(tw_wide >> stage);
  assign wr       = TW_RE[tw_idx];
  assign wi       = TW_IM[tw_idx];

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_M0:   begin mult_a = wr;      mult_b = odd_re; end
      ST_M1:   begin mult_a = wi;      mult_b = odd_im; end
      ST_M2:   begin mult_a = wr;      mult_b = odd_im; end
      ST_M3:   begin mult_a = wi;      mult_b = odd_re; end
      ST_S0:   begin mult_a = odd_re;  mult_b = odd_re; end
      ST_S1:   begin mult_a = odd_im;  mult_b = odd_im; end
      default: begin mult_a = odd_re;  mult_b = odd_re; end
    endcase
  end

  assign tr    = acc_r >>> F;
  assign ti    = acc_i >>> F;
  assign sum_r = (ACW+1)'(even_re) + (ACW+1)'(tr);
  assign sum_i = (ACW+1)'(even_im) + (ACW+1)'(ti);
  assign dif_r = (ACW+1)'(even_re) - (ACW+1)'(tr);
  assign dif_i = (ACW+1)'(even_im) - (ACW+1)'(ti);

  always_comb begin
    we    = 1'b0;
    waddr = a_addr;
    wdata = {fsp_pkg::sat24(sum_r >>> 1), fsp_pkg::sat24(sum_i >>> 1)};
    raddr = a_addr;
    unique case (state)
      ST_IDLE: begin
        we    = in_take;
        waddr = rev_fill;
        wdata = {s_ext, DW'(0)};
      end
      ST_RD_B: raddr = b_addr;
      ST_WR_A: we = 1'b1;
      ST_WR_B: begin
        we    = 1'b1;
        waddr = b_addr;
        wdata = {fsp_pkg::sat24(dif_r >>> 1), fsp_pkg::sat24(dif_i >>> 1)};
      end
      ST_K_RD: raddr = k;
      default: raddr = a_addr;
    endcase
  end

  fsp_ram #(.WIDTH(2 * DW), .DEPTH(POINTS)) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sq_go = (state == ST_S3);

  fsp_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .go    (sq_go),
    .value ({acc_r[fsp_pkg::SQ_W-3:0], 2'b00}),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign amp       = (sq_root > fsp_pkg::ROOT_W'(16'hFFFF)) ? 16'hFFFF : sq_root[15:0];
  assign k6        = fsp_pkg::BIN_W'(k);
  assign take_peak = amp > best_amp;
  assign new_bin   = take_peak ? k6 : best_bin;
  assign new_amp   = take_peak ? amp : best_amp;
  assign f_prod    = 26'(k6) * 26'(rate);
  assign pf_prod   = 26'(new_bin) * 26'(rate);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_take && fill == IDX_LAST) state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_RD_A;
      ST_RD_A:  state_next = ST_M0;
      ST_M0:    state_next = ST_M1;
      ST_M1:    state_next = ST_M2;
      ST_M2:    state_next = ST_M3;
      ST_M3:    state_next = ST_M4;
      ST_M4:    state_next = ST_WR_A;
      ST_WR_A:  state_next = ST_WR_B;
      ST_WR_B: begin
        if (bf == HALF_LAST && stage == STAGE_LAST) state_next = ST_K_RD;
        else state_next = ST_RD_B;
      end
      ST_K_RD:  state_next = ST_K_LAT;
      ST_K_LAT: state_next = ST_S0;
      ST_S0:    state_next = ST_S1;
      ST_S1:    state_next = ST_S2;
      ST_S2:    state_next = ST_S3;
      ST_S3:    state_next = ST_SQRT;
      ST_SQRT: begin
        if (sq_done) state_next = (k == HALF_LAST) ? ST_IDLE : ST_K_RD;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rate     <= fsp_pkg::RATE_RESET;
      fill     <= '0;
      bf       <= '0;
      stage    <= '0;
      k        <= '0;
      best_bin <= '0;
      best_amp <= '0;
      valid    <= 1'b0;
    end else begin
      state <= state_next;
      valid <= 1'b0;
      if (cfg_wr && paddr == fsp_pkg::REG_RATE) begin
        rate <= pwdata[fsp_pkg::RATE_W-1:0];
      end
      if (in_take) begin
        fill <= (fill == IDX_LAST) ? '0 : fill + 1'b1;
      end
      if (state == ST_WR_B) begin
        if (bf == HALF_LAST) begin
          bf <= '0;
          if (stage == STAGE_LAST) begin
            stage    <= '0;
            k        <= '0;
            best_bin <= '0;
            best_amp <= '0;
          end else begin
            stage <= stage + 1'b1;
          end
        end else begin
          bf <= bf + 1'b1;
        end
      end
      if (state == ST_SQRT && sq_done) begin
        valid    <= 1'b1;
        best_bin <= new_bin;
        best_amp <= new_amp;
        k        <= k + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mult_a * mult_b;
    case (state)
      ST_RD_A:  begin odd_re <= rdata[2*DW-1:DW]; odd_im <= rdata[DW-1:0]; end
      ST_M0:    begin even_re <= rdata[2*DW-1:DW]; even_im <= rdata[DW-1:0]; end
      ST_M1:    acc_r <= ACW'(prod);
      ST_M2:    acc_r <= acc_r - ACW'(prod) + HALF_LSB;
      ST_M3:    acc_i <= ACW'(prod);
      ST_M4:    acc_i <= acc_i + ACW'(prod) + HALF_LSB;
      ST_K_LAT: begin odd_re <= rdata[2*DW-1:DW]; odd_im <= rdata[DW-1:0]; end
      ST_S1:    acc_r <= ACW'(prod);
      ST_S2:    acc_r <= acc_r + ACW'(prod);
      default:  acc_i <= acc_i;
    endcase
    if (state == ST_SQRT && sq_done) begin
      bin_index         <= k6;
      amplitude         <= amp;
      frequency_hz      <= fsp_pkg::FREQ_W'(f_prod >> AW);
      last              <= (k == HALF_LAST);
      peak_bin          <= new_bin;
      peak_amplitude    <= new_amp;
      peak_frequency_hz <= fsp_pkg::FREQ_W'(pf_prod >> AW);
    end
  end

  `FSP_ASSERT_NEXT(a_results_spaced, clk, rst, valid && !last, !valid,
    "results closer than the square root allows")
  `FSP_ASSERT_IMP(a_idle_only_after_last, clk, rst, valid && !busy, last,
    "block went idle before the last bin")
  `FSP_ASSERT_NEXT(a_frame_starts_fft, clk, rst, in_take && fill == IDX_LAST, busy,
    "full frame did not start the transform")
  `FSP_ASSERT_IMP(a_sqrt_when_waiting, clk, rst, sq_done, state == ST_SQRT,
    "square root finished outside the bin scan")

endmodule

// File: design/fsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/fsp_isqrt.sv
// Bit-serial floor square root, one result bit per cycle.
// Depends on fsp_pkg.
module fsp_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [fsp_pkg::SQ_W-1:0]     value,
  output logic                         done,
  output logic [fsp_pkg::ROOT_W-1:0]   root
);

  localparam int W = fsp_pkg::SQ_W;

  logic         running;
  logic [W-1:0] rem;
  logic [W-1:0] res;
  logic [W-1:0] bitv;
  logic [W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[fsp_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && bitv == W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem  <= value;
      res  <= '0;
      bitv <= W'(1) << (W - 2);
    end else if (running) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// File: verif/testbench.sv
// Self-checking bench for fft_spectrum_peak_finder: sample driver, result monitor
// and an in-bench fixed-point FFT/peak predictor. Depends on fsp_pkg and the block RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int NPTS = 128;
  localparam int NBINS = NPTS / 2;
  localparam int FRAC = 15;
  localparam int SETTLE = 60;
  localparam int TAIL = 42;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [fsp_pkg::BIN_W-1:0]  bin;
    logic [fsp_pkg::AMP_W-1:0]  amp;
    logic [fsp_pkg::FREQ_W-1:0] freq;
    logic                       last;
    logic [fsp_pkg::BIN_W-1:0]  pk_bin;
    logic [fsp_pkg::AMP_W-1:0]  pk_amp;
    logic [fsp_pkg::FREQ_W-1:0] pk_freq;
  } bin_report_t;

  logic clk, rst, start, busy, valid, last;
  logic signed [15:0] sample;
  logic [fsp_pkg::BIN_W-1:0] bin_index, peak_bin;
  logic [fsp_pkg::AMP_W-1:0] amplitude, peak_amplitude;
  logic [fsp_pkg::FREQ_W-1:0] frequency_hz, peak_frequency_hz;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  fft_spectrum_peak_finder uut (.*);

  // predictor state
  longint frame_re [NPTS];
  longint frame_im [NPTS];
  longint sin_tab [33];
  int fill;
  logic [fsp_pkg::RATE_W-1:0] rate_cfg;

  logic signed [15:0] sample_backlog [$];
  bin_report_t bins_due [$];
  int errors = 0, frames_seen = 0, samples_taken = 0, bins_checked = 0;
  int hold = 0, gap_max = 6;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Q1.15 sine of pi*i/64 via a Taylor series in Q30
  function automatic longint sine_q15(int i);
    longint unsigned x, term;
    longint acc, r;
    x = (64'd3373259426 * longint'(i)) / 64;
    term = x;
    acc = x;
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2) acc -= term;
      else acc += term;
    end
    if (acc < 0) acc = 0;
    r = (acc + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    if (r > (1 << FRAC) - 1) r = (1 << FRAC) - 1;
    return r;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [fsp_pkg::FREQ_W-1:0] bin_to_hz(int k);
    longint unsigned p;
    p = (longint'(k) * longint'(rate_cfg)) / NPTS;
    return p[fsp_pkg::FREQ_W-1:0];
  endfunction

  function automatic void queue_sample(logic signed [15:0] v);
    sample_backlog.insert(sample_backlog.size(), v);
  endfunction

  function automatic void transform_frame();
    longint wr, wi, tr, ti, er, ei, orr, oi;
    int half, stride, a, b, m;
    for (int len = 2; len <= NPTS; len <<= 1) begin
      half = len / 2;
      stride = NPTS / len;
      for (int s = 0; s < NPTS; s += len)
        for (int j = 0; j < half; j++) begin
          a = s + j;
          b = s + j + half;
          m = (j * stride) & 63;
          if (m <= 32) begin
            wr = sin_tab[32 - m];
            wi = -sin_tab[m];
          end else begin
            wr = -sin_tab[m - 32];
            wi = -sin_tab[64 - m];
          end
          orr = frame_re[b];
          oi = frame_im[b];
          tr = (wr * orr - wi * oi + (1 << (FRAC - 1))) >>> FRAC;
          ti = (wr * oi + wi * orr + (1 << (FRAC - 1))) >>> FRAC;
          er = frame_re[a];
          ei = frame_im[a];
          frame_re[a] = clamp24((er + tr) >>> 1);
          frame_im[a] = clamp24((ei + ti) >>> 1);
          frame_re[b] = clamp24((er - tr) >>> 1);
          frame_im[b] = clamp24((ei - ti) >>> 1);
        end
    end
  endfunction

  // takes one accepted sample; a full frame queues its bin reports
  function automatic void absorb_sample(logic signed [15:0] s);
    int pos;
    longint amp, best_amp;
    int best_k;
    bin_report_t r;
    pos = 0;
    for (int i = 0; i < 7; i++) pos |= ((fill >> i) & 1) << (6 - i);
    frame_re[pos] = s;
    frame_im[pos] = 0;
    fill++;
    if (fill < NPTS) return;
    fill = 0;
    transform_frame();
    best_amp = 0;
    best_k = 0;
    for (int k = 0; k < NBINS; k++) begin
      amp = root_floor(4 * (frame_re[k] * frame_re[k] + frame_im[k] * frame_im[k]));
      if (amp > 65535) amp = 65535;
      if (amp > best_amp) begin
        best_amp = amp;
        best_k = k;
      end
      r.bin = fsp_pkg::BIN_W'(k);
      r.amp = fsp_pkg::AMP_W'(amp);
      r.freq = bin_to_hz(k);
      r.last = (k == NBINS - 1);
      r.pk_bin = fsp_pkg::BIN_W'(best_k);
      r.pk_amp = fsp_pkg::AMP_W'(best_amp);
      r.pk_freq = bin_to_hz(best_k);
      bins_due.insert(bins_due.size(), r);
    end
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      sample <= '0;
      hold = 0;
    end else begin
      if (start && !busy) begin
        absorb_sample(sample);
        void'(sample_backlog.pop_front());
        samples_taken++;
        hold = $urandom_range(0, gap_max);
      end
      if (start && busy) begin
        // stalled transaction stays on the bus
      end else if (hold > 0) begin
        start <= 1'b0;
        hold--;
      end else if (sample_backlog.size() > 0) begin
        start <= 1'b1;
        sample <= sample_backlog[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    bin_report_t e;
    if (!rst && valid) begin
      if (bins_due.size() == 0) begin
        $display("%0t unexpected result: bin %0d amp %0d", $time, bin_index, amplitude);
        errors++;
      end else begin
        e = bins_due.pop_front();
        bins_checked++;
        if (last) frames_seen++;
        if ({bin_index, amplitude, frequency_hz, last, peak_bin, peak_amplitude,
             peak_frequency_hz} !== {e.bin, e.amp, e.freq, e.last, e.pk_bin, e.pk_amp,
             e.pk_freq}) begin
          $display("%0t mismatch exp bin %0d amp %0d hz %0d last %0d pk %0d/%0d/%0d",
                   $time, e.bin, e.amp, e.freq, e.last, e.pk_bin, e.pk_amp, e.pk_freq);
          $display("%0t          got bin %0d amp %0d hz %0d last %0d pk %0d/%0d/%0d",
                   $time, bin_index, amplitude, frequency_hz, last, peak_bin,
                   peak_amplitude, peak_frequency_hz);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bins outstanding", cycles, bins_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_rate(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 2'(4 * fsp_pkg::REG_RATE); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rate_cfg = v[fsp_pkg::RATE_W-1:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    // read back
    @(posedge clk);
    psel <= 1'b1; paddr <= 2'(4 * fsp_pkg::REG_RATE);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== 32'(rate_cfg)) begin
      $display("%0t rate readback exp %0d got %0d", $time, rate_cfg, prdata);
      errors++;
    end
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic drain();
    while (sample_backlog.size() > 0 || bins_due.size() > 0 || start) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int amp_t, tone, noise, v;
    for (int i = 0; i <= 32; i++) sin_tab[i] = sine_q15(i);
    fill = 0;
    rate_cfg = fsp_pkg::RATE_RESET;
    rst = 1'b1; start = 1'b0; sample = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register path: zero, one and an over-range value that gets masked
    write_rate(32'd0);
    write_rate(32'd1);
    write_rate(32'hFFFF_FFFF);

    // one full frame: noisy tone with full-scale and near-zero samples mixed in
    gap_max = 6;
    tone = $urandom_range(0, NBINS - 1);
    amp_t = $urandom_range(100, 30000);
    noise = $urandom_range(0, 2000);
    for (int i = 0; i < NPTS; i++) begin
      v = $rtoi(amp_t * $cos(6.283185307 * tone * i / NPTS))
          + $urandom_range(0, 2 * noise) - noise;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      queue_sample(16'(v));
    end
    sample_backlog[5] = 16'sh7FFF;
    sample_backlog[6] = 16'sh8000;
    sample_backlog[9] = -16'sd1;
    sample_backlog[10] = 16'sd1;
    drain();

    // a 1 MHz rate, then a back-to-back partial frame that must stay silent
    write_rate(32'd1000000);
    gap_max = 0;
    for (int i = 0; i < TAIL; i++)
      queue_sample(16'($signed($urandom_range(0, 512)) - 256));
    drain();

    $display("covered %0d samples, %0d frames, %0d bins checked", samples_taken,
             frames_seen, bins_checked);
    $display("rate writes zero, one, masked and 1 MHz; gaps of 0 to 6 cycles, partial tail");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/fsp_pkg.sv
design/fsp_ram.sv
design/fsp_isqrt.sv
design/fft_spectrum_peak_finder.sv
verif/testbench.sv
